// ===== design/uartrf_pkg.sv =====
package uartrf_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RX    = 2'd2
    } t_op;

    // Register offsets within the eight-byte window
    localparam logic [2:0] REG_DATA = 3'd0;
    localparam logic [2:0] REG_IER  = 3'd1;
    localparam logic [2:0] REG_IIR  = 3'd2;
    localparam logic [2:0] REG_LCR  = 3'd3;
    localparam logic [2:0] REG_MCR  = 3'd4;
    localparam logic [2:0] REG_LSR  = 3'd5;

    // Bit positions and fixed values
    localparam int unsigned DLAB_BIT   = 7;
    localparam int unsigned IER_RX_BIT = 0;
    localparam int unsigned IER_TX_BIT = 1;
    localparam logic [7:0]  LSR_BASE   = 8'h60;
    localparam logic [7:0]  IIR_RX     = 8'h04;
    localparam logic [7:0]  IIR_TX     = 8'h02;
    localparam logic [7:0]  IIR_NONE   = 8'h01;

    // Stream data widths
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 24;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HOLD
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the input transfer
        logic exec;   // apply the item to the register file
    } t_dp_cmd;

endpackage

// ===== design/uartrf_ctrl.sv =====
module uartrf_ctrl
    import uartrf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    s_axis_tvalid,
    output logic    s_axis_tready,
    output logic    m_axis_tvalid,
    input  logic    m_axis_tready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_HOLD;
            end
            ST_HOLD: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/uartrf_dp.sv =====
module uartrf_dp
    import uartrf_pkg::*;
#(
    parameter int unsigned RX_DEPTH = 16
)
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [1:0] i_operation,
    input  logic [2:0] i_reg_offset,
    input  logic [7:0] i_data,
    output logic [7:0] o_read_data,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_irq_level,
    output logic       o_rx_overrun
);

    localparam int unsigned AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int unsigned PW = AW + 1;
    localparam logic [PW-1:0] DEPTH_P = PW'(RX_DEPTH);
    localparam logic [PW-1:0] PTR_LAST = PW'(2 * RX_DEPTH - 1);

    // Captured item
    logic [1:0]    r_op;
    logic [2:0]    r_off;
    logic [7:0]    r_data;

    // Register file
    logic [7:0]    r_dll, n_dll;
    logic [7:0]    r_dlm, n_dlm;
    logic [7:0]    r_ier, n_ier;
    logic [7:0]    r_lcr, n_lcr;
    logic [7:0]    r_mcr, n_mcr;
    logic          r_tx_pend, n_tx_pend;
    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;

    // Receive store and its registered read port
    logic [7:0]    r_mem [RX_DEPTH];
    logic [7:0]    r_mem_q;
    logic          mem_we;
    logic [AW-1:0] head_slot;
    logic [AW-1:0] tail_slot;

    // Result register
    logic [7:0]    r_rd, n_rd;
    logic          r_txv, n_txv;
    logic [7:0]    r_txb, n_txb;
    logic          r_ovr, n_ovr;

    logic          dlab;
    logic          nonempty;
    logic          full;
    logic [PW-1:0] head_inc;
    logic [PW-1:0] tail_inc;

    // Pointers count modulo twice the depth; slot folds the upper half down
    always_comb begin
        head_slot = (r_head >= DEPTH_P) ? AW'(r_head - DEPTH_P) : AW'(r_head);
        tail_slot = (r_tail >= DEPTH_P) ? AW'(r_tail - DEPTH_P) : AW'(r_tail);
        head_inc  = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
        tail_inc  = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
    end

    assign nonempty = (r_head != r_tail);
    assign full     = nonempty && (head_slot == tail_slot);
    assign dlab     = r_lcr[DLAB_BIT];

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_off  <= i_reg_offset;
            r_data <= i_data;
        end
    end

    // Store write and read; the head entry is read every cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[tail_slot] <= r_data;
        end
        r_mem_q <= r_mem[head_slot];
    end

    // Item execution
    always_comb begin
        n_dll     = r_dll;
        n_dlm     = r_dlm;
        n_ier     = r_ier;
        n_lcr     = r_lcr;
        n_mcr     = r_mcr;
        n_tx_pend = r_tx_pend;
        n_head    = r_head;
        n_tail    = r_tail;
        n_rd      = 8'h00;
        n_txv     = 1'b0;
        n_txb     = 8'h00;
        n_ovr     = 1'b0;
        mem_we    = 1'b0;
        if (i_cmd.exec) begin
            unique case (r_op)
                OP_WRITE: begin
                    unique case (r_off)
                        REG_DATA: begin
                            if (dlab) begin
                                n_dll = r_data;
                            end else begin
                                n_txv = 1'b1;
                                n_txb = r_data;
                                if (r_ier[IER_TX_BIT]) begin
                                    n_tx_pend = 1'b1;
                                end
                            end
                        end
                        REG_IER: begin
                            if (dlab) begin
                                n_dlm = r_data;
                            end else begin
                                n_ier = r_data;
                            end
                        end
                        REG_LCR: n_lcr = r_data;
                        REG_MCR: n_mcr = r_data;
                        default: ;
                    endcase
                end
                OP_READ: begin
                    unique case (r_off)
                        REG_DATA: begin
                            if (dlab) begin
                                n_rd = r_dll;
                            end else if (nonempty) begin
                                n_rd   = r_mem_q;
                                n_head = head_inc;
                            end
                        end
                        REG_IER: n_rd = dlab ? r_dlm : r_ier;
                        REG_IIR: begin
                            if (nonempty && r_ier[IER_RX_BIT]) begin
                                n_rd = IIR_RX;
                            end else if (r_tx_pend && r_ier[IER_TX_BIT]) begin
                                n_rd      = IIR_TX;
                                n_tx_pend = 1'b0;
                            end else begin
                                n_rd = IIR_NONE;
                            end
                        end
                        REG_LCR: n_rd = r_lcr;
                        REG_MCR: n_rd = r_mcr;
                        REG_LSR: n_rd = LSR_BASE | {7'd0, nonempty};
                        default: n_rd = 8'h00;
                    endcase
                end
                OP_RX: begin
                    if (full) begin
                        n_ovr = 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        n_tail = tail_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    // Register file update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dll     <= '0;
            r_dlm     <= '0;
            r_ier     <= '0;
            r_lcr     <= '0;
            r_mcr     <= '0;
            r_tx_pend <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
        end else begin
            r_dll     <= n_dll;
            r_dlm     <= n_dlm;
            r_ier     <= n_ier;
            r_lcr     <= n_lcr;
            r_mcr     <= n_mcr;
            r_tx_pend <= n_tx_pend;
            r_head    <= n_head;
            r_tail    <= n_tail;
        end
    end

    // Result register, loaded once per item
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rd  <= n_rd;
            r_txv <= n_txv;
            r_txb <= n_txb;
            r_ovr <= n_ovr;
        end
    end

    assign o_read_data  = r_rd;
    assign o_tx_valid   = r_txv;
    assign o_tx_byte    = r_txb;
    assign o_rx_overrun = r_ovr;
    // Interrupt level follows the live register state
    assign o_irq_level  = (r_ier[IER_RX_BIT] && nonempty) ||
                          (r_ier[IER_TX_BIT] && r_tx_pend);

endmodule

// ===== design/uart_register_file.sv =====
// Reduced 16550-style UART register file. Each input transfer is one bus write,
// one bus read (offsets 0-7, DLAB in line control bit 7 maps the divisor
// latches) or one byte received from the line, selected by s_axis_tuser; each
// produces exactly one result transfer carrying the read data, any transmitted
// byte, the interrupt level after the item and a receive-overrun flag. Items are
// handled one at a time: capture, execute, present, with the result held until
// m_axis_tready takes it; the execute step reads the head entry of the receive
// store through its registered read port. The receive FIFO holds RX_DEPTH bytes;
// a byte arriving when it is full is dropped and flagged. The store needs no
// clearing after reset.
module uart_register_file
    import uartrf_pkg::*;
#(
    parameter int unsigned RX_DEPTH = 16
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // reg_offset[2:0], data[10:3], zero pad
    input  logic [1:0]             s_axis_tuser,  // operation[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // read_data[7:0], tx_valid[8],
                                                  // tx_byte[16:9], irq_level[17],
                                                  // rx_overrun[18], zero pad
);

    t_dp_cmd    cmd;
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       irq_level;
    logic       rx_overrun;

    // Sequencer
    uartrf_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (cmd)
    );

    // Registers, receive FIFO and result register
    uartrf_dp #(
        .RX_DEPTH (RX_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_operation  (s_axis_tuser),
        .i_reg_offset (s_axis_tdata[2:0]),
        .i_data       (s_axis_tdata[10:3]),
        .o_read_data  (read_data),
        .o_tx_valid   (tx_valid),
        .o_tx_byte    (tx_byte),
        .o_irq_level  (irq_level),
        .o_rx_overrun (rx_overrun)
    );

    // Result packing
    assign m_axis_tdata = {5'd0, rx_overrun, irq_level, tx_byte, tx_valid, read_data};

endmodule

// ===== tb/tb_uart_register_file.sv =====
module tb_uart_register_file;
    import uartrf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RX_DEPTH    = 16;
    localparam int unsigned PTR_W       = $clog2(RX_DEPTH) + 1;
    localparam int unsigned ITEM_TARGET = 650;
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned DRAIN_WAIT  = 10;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // reg_offset[2:0], data[10:3], zero pad
    logic [1:0]             s_axis_tuser = '0;   // operation[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // read_data[7:0], tx_valid[8],
                                                 // tx_byte[16:9], irq_level[17],
                                                 // rx_overrun[18], zero pad

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq_level;
        logic       rx_overrun;
    } t_uart_result;

    // Register file predictor plus the queue of results it expects
    class uart_result_board;
        logic [7:0]       divisor_low, divisor_high, int_enable, line_control, modem_control;
        logic [7:0]       rx_store [RX_DEPTH];
        logic [PTR_W-1:0] rx_head, rx_tail;
        logic             tx_pending;
        t_uart_result     expected_results[$];
        int               failures;

        function new();
            divisor_low   = '0;
            divisor_high  = '0;
            int_enable    = '0;
            line_control  = '0;
            modem_control = '0;
            rx_head       = '0;
            rx_tail       = '0;
            tx_pending    = 1'b0;
            failures      = 0;
        endfunction

        function logic rx_ready();
            return rx_head != rx_tail;
        endfunction

        // Apply one accepted input transfer and queue its result
        function void note_item(logic [1:0] op, logic [2:0] off, logic [7:0] d);
            t_uart_result     res;
            logic             dlab;
            logic [PTR_W-1:0] fill;
            res  = '0;
            dlab = line_control[DLAB_BIT];
            fill = rx_tail - rx_head;
            case (op)
                OP_WRITE: begin
                    case (off)
                        REG_DATA: begin
                            if (dlab) begin
                                divisor_low = d;
                            end else begin
                                res.tx_valid = 1'b1;
                                res.tx_byte  = d;
                                if (int_enable[IER_TX_BIT]) tx_pending = 1'b1;
                            end
                        end
                        REG_IER: begin
                            if (dlab) divisor_high = d;
                            else int_enable = d;
                        end
                        REG_LCR: line_control  = d;
                        REG_MCR: modem_control = d;
                        default: ;
                    endcase
                end
                OP_READ: begin
                    case (off)
                        REG_DATA: begin
                            if (dlab) begin
                                res.read_data = divisor_low;
                            end else if (rx_ready()) begin
                                res.read_data = rx_store[rx_head[PTR_W-2:0]];
                                rx_head = rx_head + 1'b1;
                            end
                        end
                        REG_IER: res.read_data = dlab ? divisor_high : int_enable;
                        REG_IIR: begin
                            if (rx_ready() && int_enable[IER_RX_BIT]) begin
                                res.read_data = IIR_RX;
                            end else if (tx_pending && int_enable[IER_TX_BIT]) begin
                                res.read_data = IIR_TX;
                                tx_pending = 1'b0;
                            end else begin
                                res.read_data = IIR_NONE;
                            end
                        end
                        REG_LCR: res.read_data = line_control;
                        REG_MCR: res.read_data = modem_control;
                        REG_LSR: res.read_data = LSR_BASE | {7'd0, rx_ready()};
                        default: res.read_data = '0;
                    endcase
                end
                OP_RX: begin
                    if (fill == PTR_W'(RX_DEPTH)) begin
                        res.rx_overrun = 1'b1;
                    end else begin
                        rx_store[rx_tail[PTR_W-2:0]] = d;
                        rx_tail = rx_tail + 1'b1;
                    end
                end
                default: ;
            endcase
            res.irq_level = (int_enable[IER_RX_BIT] && rx_ready()) ||
                            (int_enable[IER_TX_BIT] && tx_pending);
            expected_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
                failures++;
            end
        endfunction

        // Compare one result transfer with the oldest expectation
        function void check_result(logic [OUT_TDATA_W-1:0] t);
            t_uart_result want;
            if (expected_results.size() == 0) begin
                $error("result 0x%06h arrived with no expectation pending", t);
                failures++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("read_data",  want.read_data,         t[7:0]);
            compare_field("tx_valid",   {7'd0, want.tx_valid},   {7'd0, t[8]});
            compare_field("tx_byte",    want.tx_byte,           t[16:9]);
            compare_field("irq_level",  {7'd0, want.irq_level},  {7'd0, t[17]});
            compare_field("rx_overrun", {7'd0, want.rx_overrun}, {7'd0, t[18]});
        endfunction
    endclass

    uart_result_board board = new();
    int               src_burst = 0;
    int               snk_burst = 0;
    int               idle_cycles = 0;
    int               items_sent = 0;

    uart_register_file #(
        .RX_DEPTH(RX_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, and now and then a gap-free stretch
    function automatic int pick_gap(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    // One input transfer, with a random idle gap ahead of it
    task automatic send_item(logic [1:0] op, logic [2:0] off, logic [7:0] d);
        int gap;
        gap = pick_gap(src_burst);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, d, off};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_item(op, off, d);
        items_sent++;
    endtask

    task automatic send_random_item();
        int         r;
        logic [2:0] off;
        logic [7:0] d;
        r   = $urandom_range(0, 99);
        off = 3'($urandom_range(0, 7));
        d   = 8'($urandom_range(0, 255));
        if (r < 2) begin
            send_item(OP_UNUSED, off, d);
        end else if (r < 32) begin
            send_item(OP_RX, off, d);
        end else if (r < 62) begin
            // lean on the data, interrupt-ID and status registers
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 2))
                    0: off = REG_DATA;
                    1: off = REG_IIR;
                    default: off = REG_LSR;
                endcase
            end
            send_item(OP_READ, off, d);
        end else begin
            if ($urandom_range(0, 4) < 2) off = REG_DATA;
            if (off == REG_LCR && $urandom_range(0, 3) != 0) d[DLAB_BIT] = 1'b0;
            send_item(OP_WRITE, off, d);
        end
    endtask

    // Result side: random stalls, check every transfer
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = pick_gap(snk_burst);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            board.check_result(m_axis_tdata);
        end
    end

    // Watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("uart_register_file test failed");
                $finish;
            end
        end
    end

    initial begin
        int r;
        int n;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset values, both interrupt sources, divisor latches, ignored slots
        send_item(OP_READ,  REG_IIR,  8'h00);
        send_item(OP_READ,  REG_LSR,  8'h00);
        send_item(OP_READ,  REG_DATA, 8'h00);   // empty FIFO reads zero
        send_item(OP_WRITE, REG_DATA, 8'h5A);   // transmit, no pending with IER clear
        send_item(OP_WRITE, REG_IER,  8'h03);
        send_item(OP_WRITE, REG_DATA, 8'h00);
        send_item(OP_READ,  REG_IIR,  8'h00);   // transmit ID, clears pending
        send_item(OP_READ,  REG_IIR,  8'h00);
        send_item(OP_WRITE, REG_DATA, 8'hFF);
        send_item(OP_RX,    3'd7,     8'hA5);   // offset ignored on receive
        send_item(OP_READ,  REG_LSR,  8'h00);
        send_item(OP_READ,  REG_IIR,  8'h00);   // receive wins over transmit
        send_item(OP_READ,  REG_DATA, 8'h00);
        send_item(OP_READ,  REG_IIR,  8'h00);
        send_item(OP_WRITE, REG_LCR,  8'h80);
        send_item(OP_WRITE, REG_DATA, 8'hFF);
        send_item(OP_WRITE, REG_IER,  8'h12);
        send_item(OP_READ,  REG_DATA, 8'h00);
        send_item(OP_READ,  REG_IER,  8'h00);
        send_item(OP_WRITE, REG_LCR,  8'h7F);
        send_item(OP_READ,  REG_LCR,  8'h00);
        send_item(OP_WRITE, REG_MCR,  8'hFF);
        send_item(OP_READ,  REG_MCR,  8'h00);
        send_item(OP_WRITE, REG_IIR,  8'hC7);   // FIFO control has no effect
        send_item(OP_WRITE, 3'd7,     8'hFF);
        send_item(OP_READ,  3'd6,     8'h00);
        send_item(OP_UNUSED, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));

        // Random: single items mixed with FIFO fill-past-full and drain runs
        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                n = RX_DEPTH + $urandom_range(1, 4);
                repeat (n) send_item(OP_RX, 3'($urandom_range(0, 7)),
                                     8'($urandom_range(0, 255)));
            end else if (r < 12) begin
                send_item(OP_WRITE, REG_LCR, 8'($urandom_range(0, 127)));
                repeat (RX_DEPTH + 2) send_item(OP_READ, REG_DATA, 8'($urandom_range(0, 255)));
            end else begin
                send_random_item();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (board.expected_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (board.failures == 0) begin
            $display("uart_register_file test passed");
        end else begin
            $display("uart_register_file test failed");
        end
        $finish;
    end

endmodule
